@@ hdl/whf_pkg.sv @@
// ----------------------------------------------------------------------------
// whf_pkg
// Shared types, constants and saturating Q32.32 helpers for the wall heat
// flux boundary coefficient pipeline.
// ----------------------------------------------------------------------------
package whf_pkg;

  localparam int QW = 64;
  localparam int FW = 32;
  localparam int DIV_STEPS = 96;
  localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [63:0] SIGMA_Q56 = 64'd4085935379;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_COND   = 3'd1,
    REG_POWER  = 3'd2,
    REG_TAMB   = 3'd3,
    REG_EPS    = 3'd4,
    REG_RELAX  = 3'd5,
    REG_RRELAX = 3'd6,
    REG_USERAD = 3'd7
  } reg_idx_t;

  localparam logic [1:0] MODE_POWER = 2'd0;
  localparam logic [1:0] MODE_FLUX  = 2'd1;
  localparam logic [1:0] MODE_HTC   = 2'd2;

  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
  } div_req_t;

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    mag = a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
    if (!neg) from_mag = m[63] ? S_MAX : $signed(m);
    else if (m[63]) from_mag = S_MIN;
    else from_mag = -$signed(m);
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sadd = s[64] ? S_MIN : S_MAX;
    else sadd = s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) ssub = s[64] ? S_MIN : S_MAX;
    else ssub = s[63:0];
  endfunction

  // saturate a magnitude product shifted right by sh (32 or 56)
  function automatic logic signed [63:0] prod_sat(input logic neg, input logic [127:0] p,
                                                  input logic sh56);
    logic [127:0] s;
    s = sh56 ? (p >> 56) : (p >> 32);
    if (s[127:64] != 64'd0) prod_sat = neg ? S_MIN : S_MAX;
    else prod_sat = from_mag(neg, s[63:0]);
  endfunction

endpackage

@@ hdl/whf_mul.sv @@
// ----------------------------------------------------------------------------
// whf_mul
// Two-stage pipelined Q32.32 signed multiply with truncation and saturation.
// Partial products are registered before the final sum.
// ----------------------------------------------------------------------------
module whf_mul (
  input  logic               clk,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic               sh56,
  output logic signed [63:0] p
);
  logic [63:0] ma, mb;
  logic [63:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic        neg, sh;
  logic [127:0] full;

  assign ma = whf_pkg::mag(a);
  assign mb = whf_pkg::mag(b);

  always_ff @(posedge clk) begin
    pp_ll <= 64'(ma[31:0]) * 64'(mb[31:0]);
    pp_lh <= 64'(ma[31:0]) * 64'(mb[63:32]);
    pp_hl <= 64'(ma[63:32]) * 64'(mb[31:0]);
    pp_hh <= 64'(ma[63:32]) * 64'(mb[63:32]);
    neg   <= a[63] ^ b[63];
    sh    <= sh56;
  end

  assign full = {64'd0, pp_ll} + ({64'd0, pp_lh} << 32) + ({64'd0, pp_hl} << 32)
              + ({pp_hh, 64'd0});

  always_ff @(posedge clk) begin
    p <= whf_pkg::prod_sat(neg, full, sh);
  end
endmodule

@@ hdl/whf_div.sv @@
// ----------------------------------------------------------------------------
// whf_div
// Pipelined Q32.32 signed divide: (a << 32) / b, one quotient bit per stage,
// with saturation and divide-by-zero handling.
// ----------------------------------------------------------------------------
module whf_div (
  input  logic               clk,
  input  whf_pkg::div_req_t  req,
  output logic signed [63:0] q
);
  localparam int N = whf_pkg::DIV_STEPS;

  localparam logic [1:0] ZC_NONE = 2'd0;
  localparam logic [1:0] ZC_POS  = 2'd1;
  localparam logic [1:0] ZC_NEG  = 2'd2;
  localparam logic [1:0] ZC_ZERO = 2'd3;

  logic [95:0]  num [0:N];
  logic [63:0]  den [0:N];
  logic [64:0]  rem [0:N];
  logic [95:0]  quo [0:N];
  logic         neg [0:N];
  logic [1:0]   zc  [0:N];

  always_ff @(posedge clk) begin
    num[0] <= {whf_pkg::mag(req.a), 32'd0};
    den[0] <= whf_pkg::mag(req.b);
    rem[0] <= 65'd0;
    quo[0] <= 96'd0;
    neg[0] <= req.a[63] ^ req.b[63];
    zc[0]  <= (req.b != 64'sd0) ? ZC_NONE : (req.a == 64'sd0 ? ZC_ZERO :
              (req.a[63] ? ZC_NEG : ZC_POS));
  end

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_step
      logic [64:0] r_sh;
      logic        take;
      assign r_sh = {rem[i][63:0], num[i][95]};
      assign take = r_sh >= {1'b0, den[i]};
      always_ff @(posedge clk) begin
        num[i+1] <= {num[i][94:0], 1'b0};
        den[i+1] <= den[i];
        rem[i+1] <= take ? (r_sh - {1'b0, den[i]}) : r_sh;
        quo[i+1] <= {quo[i][94:0], take};
        neg[i+1] <= neg[i];
        zc[i+1]  <= zc[i];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    case (zc[N])
      ZC_POS:  q <= whf_pkg::S_MAX;
      ZC_NEG:  q <= whf_pkg::S_MIN;
      ZC_ZERO: q <= 64'sd0;
      default: q <= (quo[N][95:64] != 32'd0) ? (neg[N] ? whf_pkg::S_MIN : whf_pkg::S_MAX)
                                             : whf_pkg::from_mag(neg[N], quo[N][63:0]);
    endcase
  end
endmodule

@@ hdl/wall_heat_flux_bc_coeffs_unit.sv @@
// ----------------------------------------------------------------------------
// wall_heat_flux_bc_coeffs_unit
// Mixed boundary coefficients for a heated wall face, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  config   | cfg_we, cfg_idx, cfg_data               | write when cfg_we
//  face in  | start, busy, face_temp .. prev_fraction | start & !busy
//  result   | done, ref_gradient .. rad_relaxed       | done strobe, 1 cycle
//
//  One face per cycle; busy is always low. done rises after the accepting
//  edge, through five chained multiplies for T^4, two chained divides, the
//  relaxation multiply and four single register stages.
//  Synchronous reset clears the valid line and loads register defaults.
//  The receiver cannot stall; results leave on done.
// ----------------------------------------------------------------------------
module wall_heat_flux_bc_coeffs_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [63:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic [62:0]        face_temp,
  input  logic signed [63:0] incident_rad,
  input  logic signed [63:0] prev_rad,
  input  logic signed [63:0] face_flux,
  input  logic [62:0]        face_htc,
  input  logic [62:0]        delta_coeff,
  input  logic signed [63:0] prev_ref_value,
  input  logic [32:0]        prev_fraction,
  output logic               done,
  output logic signed [63:0] ref_gradient,
  output logic signed [63:0] ref_value,
  output logic [32:0]        value_fraction,
  output logic signed [63:0] rad_relaxed
);
  localparam int ML = 2;
  localparam int DL = whf_pkg::DIV_STEPS + 2;
  // stage times, counted from the accepting edge
  localparam int T1 = ML + 1;          // qr registered
  localparam int TR = 5 * ML;          // radiation terms ready
  localparam int TH = TR + 1;          // hp/hpt registered
  localparam int TS = TH + DL;         // qr/T done
  localparam int TD = TS + 1;          // divide operands registered
  localparam int TQ = TD + DL;         // refv, vf, grad divides done
  localparam int TE = TQ + ML;         // relaxation products
  localparam int TOUT = TE + 1;

  logic [1:0]  r_mode;
  logic [62:0] r_cond, r_tamb;
  logic signed [63:0] r_power;
  logic [32:0] r_eps, r_relax, r_rrelax;
  logic        r_userad;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_mode <= 2'd1; r_cond <= 63'h1_0000_0000; r_power <= '0; r_tamb <= '0;
      r_eps <= '0; r_relax <= 33'h1_0000_0000; r_rrelax <= 33'h1_0000_0000;
      r_userad <= 1'b0;
    end else if (cfg_we) begin
      case (whf_pkg::reg_idx_t'(cfg_idx))
        whf_pkg::REG_MODE:   r_mode <= cfg_data[1:0];
        whf_pkg::REG_COND:   r_cond <= cfg_data[62:0];
        whf_pkg::REG_POWER:  r_power <= cfg_data;
        whf_pkg::REG_TAMB:   r_tamb <= cfg_data[62:0];
        whf_pkg::REG_EPS:    r_eps <= cfg_data[32:0];
        whf_pkg::REG_RELAX:  r_relax <= cfg_data[32:0];
        whf_pkg::REG_RRELAX: r_rrelax <= cfg_data[32:0];
        whf_pkg::REG_USERAD: r_userad <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input register, then delay lines for fields needed later
  typedef struct packed {
    logic [62:0] tp;
    logic signed [63:0] inc, prad, flux;
    logic [62:0] htc, dc;
    logic signed [63:0] pref;
    logic [32:0] pfrac;
  } item_t;
  item_t in0;
  always_ff @(posedge clk) begin
    in0 <= {face_temp, incident_rad, prev_rad, face_flux, face_htc, delta_coeff,
            prev_ref_value, prev_fraction};
  end

  logic signed [63:0] tp_s, tamb_s, eps_s, g_s, omg_s, kap_s, rel_s, omr_s;
  assign tp_s   = {1'b0, in0.tp};
  assign tamb_s = {1'b0, r_tamb};
  assign eps_s  = 64'(r_eps);
  assign g_s    = 64'(r_rrelax);
  assign omg_s  = whf_pkg::Q_ONE - g_s;
  assign kap_s  = {1'b0, r_cond};
  assign rel_s  = 64'(r_relax);
  assign omr_s  = whf_pkg::Q_ONE - rel_s;

  // stage A: multiplies at t=0
  logic signed [63:0] m_ginc, m_gprad, m_htct, m_kd, m_st, m_sa;
  whf_mul u_m0 (.clk, .a(g_s),   .b(in0.inc),  .sh56(1'b0), .p(m_ginc));
  whf_mul u_m1 (.clk, .a(omg_s), .b(in0.prad), .sh56(1'b0), .p(m_gprad));
  whf_mul u_m2 (.clk, .a({1'b0, in0.htc}), .b(tamb_s), .sh56(1'b0), .p(m_htct));
  whf_mul u_m3 (.clk, .a(kap_s), .b({1'b0, in0.dc}), .sh56(1'b0), .p(m_kd));
  whf_mul u_m4 (.clk, .a(tp_s),   .b(64'(whf_pkg::SIGMA_Q56)), .sh56(1'b1), .p(m_st));
  whf_mul u_m5 (.clk, .a(tamb_s), .b(64'(whf_pkg::SIGMA_Q56)), .sh56(1'b1), .p(m_sa));

  // input-field delay lines; user keeps config static while busy (unchecked)
  item_t dl [1:TQ];
  always_ff @(posedge clk) begin
    dl[1] <= in0;
    for (int k = 2; k <= TQ; k++) dl[k] <= dl[k-1];
  end

  // t = T1: qr
  logic signed [63:0] qr1;
  always_ff @(posedge clk) begin
    qr1 <= r_userad ? whf_pkg::sadd(m_ginc, m_gprad) : 64'sd0;
  end
  // radiation chain: eps*sT, then *T, *T, (*T)
  logic signed [63:0] rt_a, ra_a, rt_b, ra_b, rt_c, ra_c, ra_d;
  whf_mul u_r0 (.clk, .a(eps_s), .b(m_st), .sh56(1'b0), .p(rt_a));
  whf_mul u_r1 (.clk, .a(eps_s), .b(m_sa), .sh56(1'b0), .p(ra_a));
  whf_mul u_r2 (.clk, .a(rt_a), .b({1'b0, dl[2*ML].tp}), .sh56(1'b0), .p(rt_b));
  whf_mul u_r3 (.clk, .a(ra_a), .b(tamb_s), .sh56(1'b0), .p(ra_b));
  whf_mul u_r4 (.clk, .a(rt_b), .b({1'b0, dl[3*ML].tp}), .sh56(1'b0), .p(rt_c));
  whf_mul u_r5 (.clk, .a(ra_b), .b(tamb_s), .sh56(1'b0), .p(ra_c));
  whf_mul u_r6 (.clk, .a(ra_c), .b(tamb_s), .sh56(1'b0), .p(ra_d));

  // align qr, htc*tamb, kd and the T^3 term to ra_d at TR
  logic signed [63:0] qr_d [T1+1:TE];
  always_ff @(posedge clk) begin
    qr_d[T1+1] <= qr1;
    for (int k = T1+2; k <= TE; k++) qr_d[k] <= qr_d[k-1];
  end
  logic signed [63:0] htct_d [ML+1:TR];
  logic signed [63:0] kd_d   [ML+1:TS];
  logic signed [63:0] rtc_d  [4*ML+1:TR];
  always_ff @(posedge clk) begin
    htct_d[ML+1] <= m_htct;
    kd_d[ML+1]   <= m_kd;
    rtc_d[4*ML+1] <= rt_c;
    for (int k = ML+2; k <= TR; k++) htct_d[k] <= htct_d[k-1];
    for (int k = ML+2; k <= TS; k++) kd_d[k] <= kd_d[k-1];
    for (int k = 4*ML+2; k <= TR; k++) rtc_d[k] <= rtc_d[k-1];
  end

  // t = TR: hp, hpt (registered -> TR+1)
  logic signed [63:0] hp, hpt;
  always_ff @(posedge clk) begin
    if (r_eps != 33'd0) begin
      hp  <= whf_pkg::sadd({1'b0, dl[TR].htc}, rtc_d[TR]);
      hpt <= whf_pkg::sadd(htct_d[TR], ra_d);
    end else begin
      hp  <= {1'b0, dl[TR].htc};
      hpt <= htct_d[TR];
    end
  end

  // divide qr / T starting at TH, result at TH+DL
  logic signed [63:0] qrt;
  whf_pkg::div_req_t rq0, rq1, rq2, rq3;
  assign rq0 = '{a: qr_d[TH], b: {1'b0, dl[TH].tp}};
  whf_div u_d0 (.clk, .req(rq0), .q(qrt));
  logic signed [63:0] hp_d [TH+1:TH+DL];
  logic signed [63:0] hpt_d [TH+1:TH+DL];
  always_ff @(posedge clk) begin
    hp_d[TH+1] <= hp; hpt_d[TH+1] <= hpt;
    for (int k = TH+2; k <= TH+DL; k++) begin
      hp_d[k] <= hp_d[k-1]; hpt_d[k] <= hpt_d[k-1];
    end
  end
  // select numerators/denominators, register -> TS+1
  logic signed [63:0] num_r, den_r, hh, hk;
  assign hh = qr_d[TS][63] ? whf_pkg::ssub(hp_d[TS], qrt) : hp_d[TS];
  always_ff @(posedge clk) begin
    num_r <= qr_d[TS][63] ? hpt_d[TS] : whf_pkg::sadd(hpt_d[TS], qr_d[TS]);
    den_r <= hh;
    hk    <= whf_pkg::sadd(hh, kd_d[TS]);
  end
  logic signed [63:0] refv_h, vf_h;
  assign rq1 = '{a: num_r, b: den_r};
  assign rq2 = '{a: den_r, b: hk};
  whf_div u_d1 (.clk, .req(rq1), .q(refv_h));
  whf_div u_d2 (.clk, .req(rq2), .q(vf_h));

  // grad path: divide (q + qr) / kappa, issued at TD so it lands with the others
  logic signed [63:0] gnum, grad;
  always_ff @(posedge clk) begin
    gnum <= whf_pkg::sadd((r_mode == whf_pkg::MODE_POWER) ? r_power : dl[TS].flux, qr_d[TS]);
  end
  assign rq3 = '{a: gnum, b: kap_s};
  whf_div u_d3 (.clk, .req(rq3), .q(grad));

  // select refv / vf at TQ
  logic is_htc;
  logic signed [63:0] refv_s, vf_s;
  assign is_htc = (r_mode == whf_pkg::MODE_HTC);
  assign refv_s = is_htc ? refv_h : {1'b0, dl[TQ].tp};
  assign vf_s   = is_htc ? vf_h : 64'sd0;

  logic signed [63:0] m_rv, m_rp, m_fv, m_fp;
  whf_mul u_f0 (.clk, .a(rel_s), .b(vf_s),   .sh56(1'b0), .p(m_fv));
  whf_mul u_f1 (.clk, .a(omr_s), .b(64'(dl[TQ].pfrac)), .sh56(1'b0), .p(m_fp));
  whf_mul u_f2 (.clk, .a(rel_s), .b(refv_s), .sh56(1'b0), .p(m_rv));
  whf_mul u_f3 (.clk, .a(omr_s), .b(dl[TQ].pref), .sh56(1'b0), .p(m_rp));
  logic signed [63:0] grad_d [TQ+1:TQ+ML];
  always_ff @(posedge clk) begin
    grad_d[TQ+1] <= is_htc ? 64'sd0 : grad;
    for (int k = TQ+2; k <= TQ+ML; k++) grad_d[k] <= grad_d[k-1];
  end

  logic signed [63:0] vfsum;
  assign vfsum = whf_pkg::sadd(m_fv, m_fp);
  always_ff @(posedge clk) begin
    ref_gradient <= grad_d[TE];
    ref_value    <= whf_pkg::sadd(m_rv, m_rp);
    value_fraction <= vfsum[63] ? 33'd0 : (vfsum > whf_pkg::Q_ONE ? 33'h1_0000_0000
                                                                   : vfsum[32:0]);
    rad_relaxed  <= qr_d[TE];
  end
  // valid line
  logic [TOUT:0] ov;
  always_ff @(posedge clk) begin
    if (rst) ov <= '0;
    else ov <= {ov[TOUT-1:0], start};
  end
  assign done = ov[TOUT];

`ifndef SYNTHESIS
  a_busy_low: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_vf_range: assert property (@(posedge clk) disable iff (rst)
    done |-> value_fraction <= 33'h1_0000_0000) else $error("fraction out of range");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(start, TOUT+1)) else $error("result without item");
  a_htc_grad: assert property (@(posedge clk) disable iff (rst)
    (done && r_mode == whf_pkg::MODE_HTC) |-> ref_gradient == 64'sd0)
    else $error("nonzero gradient in coefficient mode");
`endif
endmodule
